// File: hw/rtl/wrr_pkg.sv
`timescale 1ns / 1ps

package wrr_pkg;

    // Default field limits
    localparam int unsigned MAX_WIDTH_DEF  = 256;
    localparam int unsigned MAX_HEIGHT_DEF = 256;

    // Command queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPW    = 2;

    // Opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STONE  = 2'd1;
    localparam logic [1:0] OP_WAVE   = 2'd2;
    localparam logic [1:0] OP_RENDER = 2'd3;

    // Register index (paddr bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [8:0] FIELD_RESET = 9'd256;

    // Refraction: unit depth 1024, damping divides by 32
    localparam logic signed [15:0] UNIT_DEPTH    = 16'sd1024;
    localparam int unsigned        REFRACT_SHIFT = 10;
    localparam int unsigned        DAMP_SHIFT    = 5;
    localparam logic signed [15:0] DAMP_BIAS     = 16'sd31;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         x_coord;
        logic [7:0]         y_coord;
        logic [31:0]        pixel_in;
        logic [3:0]         stone_radius;
        logic signed [15:0] stone_weight;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic [7:0]  source_x;
        logic [7:0]  source_y;
        logic        status;
    } t_out_item;

    // Classified command: reject set when coordinates are out of range
    typedef struct packed {
        t_in_item item;
        logic     rej;
    } t_cmd;

endpackage

// File: hw/rtl/wrr_ram.sv
`timescale 1ns / 1ps

module wrr_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic [AW-1:0]    i_ra_a,
    input  logic [AW-1:0]    i_ra_b,
    output logic [WIDTH-1:0] o_rd_a,
    output logic [WIDTH-1:0] o_rd_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd_a <= r_mem[i_ra_a];
        o_rd_b <= r_mem[i_ra_b];
    end

endmodule

// File: hw/rtl/wrr_front.sv
`timescale 1ns / 1ps

module wrr_front #(
    parameter int unsigned WB = 9,
    parameter int unsigned HB = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [WB-1:0]        i_w,
    input  logic [HB-1:0]        i_h,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  wrr_pkg::t_in_item    i_in_data,
    output logic                 o_q_valid,
    output wrr_pkg::t_cmd        o_q_cmd,
    input  logic                 i_q_pop
);

    wrr_pkg::t_cmd                r_mem [wrr_pkg::QDEPTH];
    logic [wrr_pkg::QPW-1:0]      r_wp;
    logic [wrr_pkg::QPW-1:0]      r_rp;
    logic [wrr_pkg::QPW:0]        r_cnt;
    logic                         full;
    logic                         push;
    logic                         pop;
    logic [8:0]                   xr;
    logic [8:0]                   yr;
    logic                         off_field;
    logic                         rej;
    wrr_pkg::t_cmd                cmd;

    // Range classification
    assign xr        = 9'(i_in_data.x_coord) + 9'(i_in_data.stone_radius);
    assign yr        = 9'(i_in_data.y_coord) + 9'(i_in_data.stone_radius);
    assign off_field = (i_in_data.x_coord >= i_w) || (i_in_data.y_coord >= i_h);

    always_comb begin
        unique case (i_in_data.opcode)
            wrr_pkg::OP_LOAD:   rej = off_field;
            wrr_pkg::OP_STONE:  rej = (xr >= i_w) || (yr >= i_h)
                                   || (i_in_data.x_coord < 8'(i_in_data.stone_radius))
                                   || (i_in_data.y_coord < 8'(i_in_data.stone_radius));
            wrr_pkg::OP_WAVE:   rej = 1'b0;
            wrr_pkg::OP_RENDER: rej = off_field;
            default:            rej = 1'b0;
        endcase
    end

    assign cmd.item = i_in_data;
    assign cmd.rej  = rej;

    // Command queue
    assign full       = (r_cnt == (wrr_pkg::QPW + 1)'(wrr_pkg::QDEPTH));
    assign o_in_stall = full;
    assign push       = i_in_valid && !full;
    assign o_q_valid  = (r_cnt != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_cmd    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= cmd;
    end

endmodule

// File: hw/rtl/wrr_back.sv
`timescale 1ns / 1ps

module wrr_back #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256,
    localparam int unsigned WB    = $clog2(MAX_WIDTH + 1),
    localparam int unsigned HB    = $clog2(MAX_HEIGHT + 1),
    localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT,
    localparam int unsigned AW    = $clog2(CELLS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [WB-1:0]      i_w,
    input  logic [HB-1:0]      i_h,
    input  logic               i_q_valid,
    input  wrr_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wrr_pkg::t_out_item o_out_data
);

    localparam int unsigned MB = (WB > HB) ? WB : HB;
    localparam int unsigned CB = ((MB > 9) ? MB : 9) + 1;
    localparam int unsigned PB = CB + 16;
    localparam int unsigned LW = 8 + WB + 1;
    localparam int unsigned LW2 = HB + WB + 1;
    localparam logic signed [PB-1:0] RND_BIAS = PB'((1 << wrr_pkg::REFRACT_SHIFT) - 1);

    typedef enum logic [15:0] {
        S_CLEAR    = 16'h0001,
        S_IDLE     = 16'h0002,
        S_LOAD     = 16'h0004,
        S_STN_ADDR = 16'h0008,
        S_STN_RD   = 16'h0010,
        S_STN_WR   = 16'h0020,
        S_WAV_INIT = 16'h0040,
        S_WAV_0    = 16'h0080,
        S_WAV_1    = 16'h0100,
        S_WAV_2    = 16'h0200,
        S_RND_0    = 16'h0400,
        S_RND_1    = 16'h0800,
        S_RND_2    = 16'h1000,
        S_RND_3    = 16'h2000,
        S_RND_4    = 16'h4000,
        S_RESP     = 16'h8000
    } t_state;

    t_state             r_state, n_state;
    wrr_pkg::t_cmd      r_cmd;
    logic [AW-1:0]      r_k, r_i, r_end, r_clr;
    logic signed [4:0]  r_dx, r_dy;
    logic signed [17:0] r_sum;
    logic signed [15:0] r_old;
    logic signed [PB-1:0] r_pa, r_pb;
    logic [WB-1:0]      r_a;
    logic [HB-1:0]      r_b;
    wrr_pkg::t_out_item r_res, r_out;
    logic               r_ovalid, n_ovalid;
    logic               r_sel;

    logic               slot_free;
    logic               clr_last;
    logic [LW-1:0]      head_lin, stn_lin;
    logic signed [8:0]  px, py;
    logic signed [9:0]  sqx, sqy;
    logic [9:0]         dsq;
    logic [7:0]         rr;
    logic signed [4:0]  rm1, neg_r;
    logic               stn_inside, stn_last, dy_last, wav_last;
    logic signed [17:0] wsum;
    logic signed [16:0] whalf;
    logic signed [17:0] wdiff;
    logic signed [15:0] wv, wt, wnew;
    logic signed [15:0] depth;
    logic signed [CB-1:0] xd, yd;
    logic signed [PB-1:0] bias_a, bias_b, qa, qb, araw, braw, wm1_s, hm1_s;
    logic [LW2-1:0]     img_lin;

    // Plane port signals, before current/previous mapping
    logic [AW-1:0]      cur_ra, cur_rb, cur_wa, old_ra, old_wa;
    logic               cur_we, old_we;
    logic [15:0]        cur_wd, old_wd;
    logic signed [15:0] cur_rda, cur_rdb, old_rd;
    logic [15:0]        a_rda, a_rdb, b_rda, b_rdb;
    logic [AW-1:0]      a_ra, a_rb, a_wa, b_ra, b_rb, b_wa;
    logic               a_we, b_we;
    logic [15:0]        a_wd, b_wd;
    logic [31:0]        img_rd;
    logic [AW-1:0]      img_ra;

    assign slot_free = !r_ovalid || !i_out_stall;
    assign clr_last  = (r_clr == AW'(CELLS - 1));
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;

    // Linear address of the queued command position
    assign head_lin = LW'(i_q_cmd.item.y_coord) * LW'(i_w) + LW'(i_q_cmd.item.x_coord);

    // Stone disk walk
    assign px       = $signed({1'b0, r_cmd.item.x_coord}) + 9'(r_dx);
    assign py       = $signed({1'b0, r_cmd.item.y_coord}) + 9'(r_dy);
    assign stn_lin  = LW'(py[7:0]) * LW'(i_w) + LW'(px[7:0]);
    assign sqx      = r_dx * r_dx;
    assign sqy      = r_dy * r_dy;
    assign dsq      = $unsigned(sqx) + $unsigned(sqy);
    assign rr       = 8'(r_cmd.item.stone_radius) * 8'(r_cmd.item.stone_radius);
    assign stn_inside = dsq < 10'(rr);
    assign rm1      = $signed(5'(r_cmd.item.stone_radius)) - 5'sd1;
    assign neg_r    = -$signed(5'(r_cmd.item.stone_radius));
    assign dy_last  = (r_dy == rm1);
    assign stn_last = dy_last && (r_dx == rm1);

    // Wave update of one cell
    assign wsum  = r_sum + 18'(cur_rda) + 18'(cur_rdb);
    assign whalf = 17'(wsum >>> 1);
    assign wdiff = 18'(whalf) - 18'(r_old);
    assign wv    = wdiff[15:0];
    assign wt    = wv[15] ? ((wv + wrr_pkg::DAMP_BIAS) >>> wrr_pkg::DAMP_SHIFT)
                          : (wv >>> wrr_pkg::DAMP_SHIFT);
    assign wnew  = wv - wt;
    assign wav_last = (r_i == r_end - 1'b1);

    // Refraction offsets
    assign depth = wrr_pkg::UNIT_DEPTH - cur_rda;
    assign xd = CB'($signed({1'b0, r_cmd.item.x_coord}))
              - CB'($signed({1'b0, i_w[WB-1:1]}));
    assign yd = CB'($signed({1'b0, r_cmd.item.y_coord}))
              - CB'($signed({1'b0, i_h[HB-1:1]}));
    assign bias_a = r_pa[PB-1] ? RND_BIAS : '0;
    assign bias_b = r_pb[PB-1] ? RND_BIAS : '0;
    assign qa    = (r_pa + bias_a) >>> wrr_pkg::REFRACT_SHIFT;
    assign qb    = (r_pb + bias_b) >>> wrr_pkg::REFRACT_SHIFT;
    assign araw  = qa + PB'($signed({1'b0, i_w[WB-1:1]}));
    assign braw  = qb + PB'($signed({1'b0, i_h[HB-1:1]}));
    assign wm1_s = PB'(i_w - WB'(1));
    assign hm1_s = PB'(i_h - HB'(1));
    assign img_lin = LW2'(r_b) * LW2'(i_w) + LW2'(r_a);
    assign img_ra  = AW'(img_lin);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    n_state = clr_last ? S_IDLE : S_CLEAR;
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.rej) begin
                        n_state = S_RESP;
                    end else begin
                        unique case (i_q_cmd.item.opcode)
                            wrr_pkg::OP_LOAD:   n_state = S_LOAD;
                            wrr_pkg::OP_STONE:  n_state = (i_q_cmd.item.stone_radius == '0)
                                                          ? S_RESP : S_STN_ADDR;
                            wrr_pkg::OP_WAVE:   n_state = S_WAV_INIT;
                            wrr_pkg::OP_RENDER: n_state = S_RND_0;
                            default:            n_state = S_RESP;
                        endcase
                    end
                end
            end
            S_LOAD:     n_state = S_RESP;
            S_STN_ADDR: n_state = stn_inside ? S_STN_RD : (stn_last ? S_RESP : S_STN_ADDR);
            S_STN_RD:   n_state = S_STN_WR;
            S_STN_WR:   n_state = stn_last ? S_RESP : S_STN_ADDR;
            S_WAV_INIT: n_state = S_WAV_0;
            S_WAV_0:    n_state = S_WAV_1;
            S_WAV_1:    n_state = S_WAV_2;
            S_WAV_2:    n_state = wav_last ? S_RESP : S_WAV_0;
            S_RND_0:    n_state = S_RND_1;
            S_RND_1:    n_state = S_RND_2;
            S_RND_2:    n_state = S_RND_3;
            S_RND_3:    n_state = S_RND_4;
            S_RND_4:    n_state = S_RESP;
            S_RESP:     n_state = slot_free ? S_IDLE : S_RESP;
            default:    n_state = S_CLEAR;
        endcase
    end

    assign n_ovalid = ((r_state == S_RESP) && slot_free) || (r_ovalid && i_out_stall);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_sel    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_WAV_2 && wav_last) r_sel <= !r_sel;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP && slot_free) r_out <= r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_cmd <= i_q_cmd;
                    r_k   <= AW'(head_lin);
                    r_dx  <= -$signed(5'(i_q_cmd.item.stone_radius));
                    r_dy  <= -$signed(5'(i_q_cmd.item.stone_radius));
                    r_res <= '{pixel_out: 32'd0, source_x: 8'd0, source_y: 8'd0,
                               status: i_q_cmd.rej};
                end
            end
            S_STN_ADDR: begin
                r_k <= AW'(stn_lin);
                if (!stn_inside) begin
                    if (dy_last) begin
                        r_dy <= neg_r;
                        r_dx <= r_dx + 5'sd1;
                    end else begin
                        r_dy <= r_dy + 5'sd1;
                    end
                end
            end
            S_STN_WR: begin
                if (dy_last) begin
                    r_dy <= neg_r;
                    r_dx <= r_dx + 5'sd1;
                end else begin
                    r_dy <= r_dy + 5'sd1;
                end
            end
            S_WAV_INIT: begin
                r_end <= AW'(LW2'(i_w) * LW2'(i_h - HB'(1)));
                r_i   <= AW'(i_w);
            end
            S_WAV_1: begin
                r_sum <= 18'(cur_rda) + 18'(cur_rdb);
                r_old <= old_rd;
            end
            S_WAV_2: r_i <= r_i + 1'b1;
            S_RND_1: begin
                r_pa <= PB'(xd) * PB'(depth);
                r_pb <= PB'(yd) * PB'(depth);
            end
            S_RND_2: begin
                if (araw[PB-1]) begin
                    r_a <= '0;
                end else if (araw > wm1_s) begin
                    r_a <= i_w - WB'(1);
                end else begin
                    r_a <= WB'(araw);
                end
                if (braw[PB-1]) begin
                    r_b <= '0;
                end else if (braw > hm1_s) begin
                    r_b <= i_h - HB'(1);
                end else begin
                    r_b <= HB'(braw);
                end
            end
            S_RND_4: begin
                r_res <= '{pixel_out: img_rd, source_x: 8'(r_a), source_y: 8'(r_b),
                           status: 1'b0};
            end
            default: ;
        endcase
    end

    // Current and previous plane ports
    always_comb begin
        cur_ra = (r_state == S_WAV_0) ? (r_i - AW'(i_w)) :
                 (r_state == S_WAV_1) ? (r_i - 1'b1) : r_k;
        cur_rb = (r_state == S_WAV_0) ? (r_i + AW'(i_w)) : (r_i + 1'b1);
        cur_we = (r_state == S_CLEAR) || (r_state == S_STN_WR);
        cur_wa = (r_state == S_CLEAR) ? r_clr : r_k;
        cur_wd = (r_state == S_CLEAR) ? 16'd0 : 16'(cur_rda + r_cmd.item.stone_weight);
        old_ra = r_i;
        old_we = (r_state == S_CLEAR) || (r_state == S_WAV_2);
        old_wa = (r_state == S_CLEAR) ? r_clr : r_i;
        old_wd = (r_state == S_CLEAR) ? 16'd0 : wnew;
    end

    assign a_ra = r_sel ? old_ra : cur_ra;
    assign a_rb = r_sel ? old_ra : cur_rb;
    assign a_we = r_sel ? old_we : cur_we;
    assign a_wa = r_sel ? old_wa : cur_wa;
    assign a_wd = r_sel ? old_wd : cur_wd;
    assign b_ra = r_sel ? cur_ra : old_ra;
    assign b_rb = r_sel ? cur_rb : old_ra;
    assign b_we = r_sel ? cur_we : old_we;
    assign b_wa = r_sel ? cur_wa : old_wa;
    assign b_wd = r_sel ? cur_wd : old_wd;

    assign cur_rda = r_sel ? b_rda : a_rda;
    assign cur_rdb = r_sel ? b_rdb : a_rdb;
    assign old_rd  = r_sel ? a_rda : b_rda;

    wrr_ram #(.WIDTH(16), .DEPTH(CELLS)) u_plane_a (
        .i_clk  (i_clk),
        .i_we   (a_we),
        .i_wa   (a_wa),
        .i_wd   (a_wd),
        .i_ra_a (a_ra),
        .i_ra_b (a_rb),
        .o_rd_a (a_rda),
        .o_rd_b (a_rdb)
    );

    wrr_ram #(.WIDTH(16), .DEPTH(CELLS)) u_plane_b (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_wa   (b_wa),
        .i_wd   (b_wd),
        .i_ra_a (b_ra),
        .i_ra_b (b_rb),
        .o_rd_a (b_rda),
        .o_rd_b (b_rdb)
    );

    // Source image
    wrr_ram #(.WIDTH(32), .DEPTH(CELLS)) u_image (
        .i_clk  (i_clk),
        .i_we   (r_state == S_LOAD),
        .i_wa   (r_k),
        .i_wd   (r_cmd.item.pixel_in),
        .i_ra_a (img_ra),
        .i_ra_b (img_ra),
        .o_rd_a (img_rd),
        .o_rd_b ()
    );

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/water_ripple_refraction.sv
`timescale 1ns / 1ps

// Water ripple engine with refraction rendering. A front stage range-checks each
// transaction and queues it (four entries); a back-end sequencer executes it
// against two dual-read-port height-plane RAMs and a source image RAM, and
// returns exactly one result per transaction through an output register.
// Each command includes a queue pop and a result hand-off. A render pixel
// takes one read of the height plane, the displacement multiply, clamp, then
// one image read; dropping a stone visits every cell of the 2r x 2r square,
// reading and writing the disk cells; a wave step covers W * (H - 2) cells,
// with two neighbor reads per RAM read cycle, then the write of the previous
// plane. After reset a clearing pass writes zero to both planes, one cell a
// cycle, over all MAX_WIDTH * MAX_HEIGHT cells; commands queue up meanwhile
// and register writes are taken at any time.
module water_ripple_refraction #(
    parameter int unsigned MAX_WIDTH  = wrr_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = wrr_pkg::MAX_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wrr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wrr_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned WB = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HB = $clog2(MAX_HEIGHT + 1);

    logic [8:0]    r_fw, r_fh;
    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic          wr;
    logic          q_valid, q_pop;
    wrr_pkg::t_cmd q_cmd;

    // Register port
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign prdata = (paddr[2] == wrr_pkg::REG_HEIGHT) ? {23'd0, r_fh} : {23'd0, r_fw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= wrr_pkg::FIELD_RESET;
            r_fh <= wrr_pkg::FIELD_RESET;
        end else if (wr) begin
            if (paddr[2] == wrr_pkg::REG_WIDTH) begin
                r_fw <= pwdata[8:0];
            end else begin
                r_fh <= pwdata[8:0];
            end
        end
    end

    // Field size in use, clamped to 3..MAX
    always_comb begin
        priority if (r_fw < 9'd3) begin
            w_eff = WB'(3);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(r_fw);
        end
        priority if (r_fh < 9'd3) begin
            h_eff = HB'(3);
        end else if (32'(r_fh) > MAX_HEIGHT) begin
            h_eff = HB'(MAX_HEIGHT);
        end else begin
            h_eff = HB'(r_fh);
        end
    end

    wrr_front #(.WB(WB), .HB(HB)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_w        (w_eff),
        .i_h        (h_eff),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    wrr_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_w         (w_eff),
        .i_h         (h_eff),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
